@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the basis evaluator checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, skipped while reset is high.
`define LBE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lbe check failed");

// Same check, also active during reset.
`define LBE_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("lbe check failed");

`endif

@@ sv/lbe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbe_pkg
// Widths, codes and shared types of the Lagrange basis evaluator.
// ----------------------------------------------------------------------------
package lbe_pkg;

   localparam int MAX_POINTS    = 6;
   localparam int IN_FRAC_BITS  = 14;
   localparam int OUT_FRAC_BITS = 24;
   localparam int NODE_W        = 16;
   localparam int CNT_W         = 3;
   localparam int IDX_W         = 3;
   localparam int DIFF_W        = NODE_W + 1;
   localparam int MAX_FACTORS   = MAX_POINTS - 1;
   localparam int PROD_W        = MAX_FACTORS * DIFF_W;
   localparam int TERM_W        = (MAX_FACTORS - 1) * DIFF_W;
   localparam int SUM_W         = TERM_W + 4;
   localparam int DIV_W         = SUM_W + IN_FRAC_BITS + OUT_FRAC_BITS;
   localparam int DIV_CNT_W     = $clog2(DIV_W + 1);
   localparam int CHUNK_W       = 32;
   localparam int NUM_CHUNKS    = (PROD_W + CHUNK_W - 1) / CHUNK_W;
   localparam int WORK_W        = NUM_CHUNKS * CHUNK_W;
   localparam int CHUNK_IDX_W   = $clog2(NUM_CHUNKS);
   localparam int RES_W         = 32;
   localparam int STATUS_W      = 2;
   localparam int REQ_TDATA_W   = ((IDX_W + NODE_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W   = 2 * RES_W;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SAT       = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO_DEN  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

   localparam logic [IDX_W-1:0] REG_POINT_COUNT = 3'd0;
   localparam logic [IDX_W-1:0] REG_NODE_BASE   = 3'd1;

   localparam logic [CNT_W-1:0] POINT_COUNT_RESET = 3'd2;
   localparam logic [NODE_W-1:0] NODE_RESET [MAX_POINTS] =
      '{16'hC000, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};

   typedef struct packed {
      logic start;
      logic neg;
   } div_cmd_type;

   typedef struct packed {
      logic             done;
      logic             sat;
      logic [RES_W-1:0] value;
   } div_res_type;

endpackage

@@ sv/lagrange_basis_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagrange_basis_eval
// Lagrange basis value and slope at a point, Q2.14 in, Q8.24 out, saturated.
// ----------------------------------------------------------------------------
// Usage:
//   req_* beat carries basis index p and point x (Q2.14). rsp_* beat carries
//   L_p(x) and L_p'(x) in Q8.24 plus a status code in rsp_tuser.
//   csr_* writes point_count (index 0) and node_0..node_5 (indexes 1..6);
//   write only while no request is in flight.
// Timing:
//   One request at a time; req_tready is high only when idle. Products are
//   built with one shared 32x17 multiplier, three 32-bit chunks per factor,
//   and the two quotients come from a 110-step bit-serial divider. A bad
//   index or a zero denominator goes to the result without any division.
// Reset:
//   Synchronous; returns to idle, point_count = 2, nodes -1.0, +1.0, 0, 0, 0, 0.
// Backpressure:
//   The result is held in output registers with rsp_tvalid high until
//   rsp_tready; no new request is taken before then.
// ----------------------------------------------------------------------------
module lagrange_basis_eval import lbe_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [2:0] basis_index, [18:3] eval_point, rest zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] basis_value, [63:32] basis_slope
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [STATUS_W-1:0]    rsp_tuser,
   input  logic                   csr_we,
   input  logic [IDX_W-1:0]       csr_index,
   input  logic [NODE_W-1:0]      csr_wdata
);

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_DEN       = 7'b0000010,
      S_NUM       = 7'b0000100,
      S_TERM      = 7'b0001000,
      S_DIV_VAL   = 7'b0010000,
      S_DIV_SLOPE = 7'b0100000,
      S_OUT       = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [CNT_W-1:0]  cnt_ff;
   logic [NODE_W-1:0] node_ff [MAX_POINTS];

   // per-request context
   logic [IDX_W-1:0]       p_ff, p_in;
   logic [CNT_W-1:0]       n_ff, n_in;
   logic [NODE_W-1:0]      x_ff, x_in;
   logic [NODE_W-1:0]      np_ff, np_in;
   logic [IDX_W-1:0]       i_ff, i_in;
   logic [IDX_W-1:0]       k_ff, k_in;
   logic [CHUNK_IDX_W-1:0] c_ff, c_in;
   logic [WORK_W-1:0]      w_ff, w_in;
   logic [WORK_W-1:0]      acc_ff, acc_in;
   logic                   sgn_ff, sgn_in;
   logic [PROD_W-1:0]      den_ff, den_in;
   logic                   den_neg_ff, den_neg_in;
   logic [PROD_W-1:0]      num_ff, num_in;
   logic                   num_neg_ff, num_neg_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   sat_ff, sat_in;
   logic [RES_W-1:0]       val_ff, val_in;
   logic [RES_W-1:0]       slope_ff, slope_in;
   logic [STATUS_W-1:0]    status_ff, status_in;

   // datapath
   logic [IDX_W-1:0]          req_p;
   logic [NODE_W-1:0]         req_x;
   logic [CNT_W-1:0]          n_eff;
   logic [IDX_W-1:0]          rd_idx;
   logic [NODE_W-1:0]         node_rd;
   logic [NODE_W-1:0]         base;
   logic [DIFF_W-1:0]         diff;
   logic                      dneg;
   logic [DIFF_W-1:0]         mag;
   logic                      skip;
   logic [CHUNK_W-1:0]        chunk;
   logic [CHUNK_W+DIFF_W-1:0] part;
   logic [WORK_W-1:0]         mac;
   logic [SUM_W-1:0]          term;
   logic [SUM_W-1:0]          sum_add;
   logic [SUM_W-1:0]          sum_mag;
   logic                      last_chunk;

   div_cmd_type      div_cmd;
   logic [DIV_W-1:0] div_dividend;
   div_res_type      div_res;

   assign req_p = req_tdata[IDX_W-1:0];
   assign req_x = req_tdata[IDX_W+NODE_W-1:IDX_W];

   // point_count clamped to [2, MAX_POINTS]
   assign n_eff = (cnt_ff < CNT_W'(2)) ? CNT_W'(2) :
                  (cnt_ff > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : cnt_ff;

   // single node read port: node_p at accept, node_i while running
   assign rd_idx  = (state_ff == S_IDLE) ? req_p : i_ff;
   assign node_rd = (rd_idx < IDX_W'(MAX_POINTS)) ? node_ff[rd_idx] : '0;

   assign base = (state_ff == S_DEN) ? np_ff : x_ff;
   assign diff = {base[NODE_W-1], base} - {node_rd[NODE_W-1], node_rd};
   assign dneg = diff[DIFF_W-1];
   assign mag  = dneg ? (DIFF_W'(0) - diff) : diff;
   assign skip = (i_ff == p_ff) || ((state_ff == S_TERM) && (i_ff == k_ff));

   // shared multiplier: one 32-bit chunk of the running product per cycle while a factor is taken
   assign chunk      = w_ff[c_ff*CHUNK_W +: CHUNK_W];
   assign part       = chunk * mag;
   assign mac        = ((c_ff == '0) ? '0 : acc_ff) +
                       (WORK_W'(part) << (c_ff * CHUNK_W));
   assign last_chunk = (c_ff == CHUNK_IDX_W'(NUM_CHUNKS - 1));

   assign term    = SUM_W'(w_ff);
   assign sum_add = sgn_ff ? (sum_ff - term) : (sum_ff + term);
   assign sum_mag = sum_ff[SUM_W-1] ? (SUM_W'(0) - sum_ff) : sum_ff;

   // divider hookup: value first, slope launched on value done
   assign div_cmd.start = ((state_ff == S_TERM) && (k_ff == n_ff)) ||
                          ((state_ff == S_DIV_VAL) && div_res.done);
   assign div_cmd.neg   = (state_ff == S_TERM) ? (num_neg_ff ^ den_neg_ff)
                                               : (sum_ff[SUM_W-1] ^ den_neg_ff);
   assign div_dividend  = (state_ff == S_TERM)
                          ? (DIV_W'(num_ff) << OUT_FRAC_BITS)
                          : (DIV_W'(sum_mag) << (IN_FRAC_BITS + OUT_FRAC_BITS));

   lbe_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (div_dividend),
      .divisor  (den_ff),
      .res      (div_res)
   );

   always_comb begin
      state_in   = state_ff;
      p_in       = p_ff;
      n_in       = n_ff;
      x_in       = x_ff;
      np_in      = np_ff;
      i_in       = i_ff;
      k_in       = k_ff;
      c_in       = c_ff;
      w_in       = w_ff;
      acc_in     = acc_ff;
      sgn_in     = sgn_ff;
      den_in     = den_ff;
      den_neg_in = den_neg_ff;
      num_in     = num_ff;
      num_neg_in = num_neg_ff;
      sum_in     = sum_ff;
      sat_in     = sat_ff;
      val_in     = val_ff;
      slope_in   = slope_ff;
      status_in  = status_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               p_in   = req_p;
               x_in   = req_x;
               np_in  = node_rd;
               n_in   = n_eff;
               i_in   = '0;
               k_in   = '0;
               c_in   = '0;
               w_in   = WORK_W'(1);
               sgn_in = 1'b0;
               sum_in = '0;
               sat_in = 1'b0;
               if (req_p >= IDX_W'(n_eff)) begin
                  val_in    = '0;
                  slope_in  = '0;
                  status_in = ST_BAD_INDEX;
                  state_in  = S_OUT;
               end else begin
                  state_in = S_DEN;
               end
            end
         end

         S_DEN, S_NUM, S_TERM: begin
            if ((state_ff == S_TERM) && (k_ff == n_ff)) begin
               state_in = S_DIV_VAL;
            end else if ((state_ff == S_TERM) && (k_ff == p_ff)) begin
               k_in = k_ff + IDX_W'(1);
            end else if (i_ff == IDX_W'(n_ff)) begin
               // product for this pass complete
               w_in   = WORK_W'(1);
               sgn_in = 1'b0;
               i_in   = '0;
               case (state_ff)
                  S_DEN: begin
                     if (w_ff[PROD_W-1:0] == '0) begin
                        val_in    = '0;
                        slope_in  = '0;
                        status_in = ST_ZERO_DEN;
                        state_in  = S_OUT;
                     end else begin
                        den_in     = w_ff[PROD_W-1:0];
                        den_neg_in = sgn_ff;
                        state_in   = S_NUM;
                     end
                  end
                  S_NUM: begin
                     num_in     = w_ff[PROD_W-1:0];
                     num_neg_in = sgn_ff;
                     k_in       = '0;
                     state_in   = S_TERM;
                  end
                  default: begin
                     sum_in = sum_add;
                     k_in   = k_ff + IDX_W'(1);
                  end
               endcase
            end else if (skip) begin
               i_in = i_ff + IDX_W'(1);
               c_in = '0;
            end else begin
               acc_in = mac;
               if (last_chunk) begin
                  w_in   = mac;
                  c_in   = '0;
                  sgn_in = sgn_ff ^ dneg;
                  i_in   = i_ff + IDX_W'(1);
               end else begin
                  c_in = c_ff + CHUNK_IDX_W'(1);
               end
            end
         end

         S_DIV_VAL: begin
            if (div_res.done) begin
               val_in   = div_res.value;
               sat_in   = div_res.sat;
               state_in = S_DIV_SLOPE;
            end
         end

         S_DIV_SLOPE: begin
            if (div_res.done) begin
               slope_in  = div_res.value;
               status_in = (sat_ff || div_res.sat) ? ST_SAT : ST_OK;
               state_in  = S_OUT;
            end
         end

         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= POINT_COUNT_RESET;
         for (int j = 0; j < MAX_POINTS; j++) begin
            node_ff[j] <= NODE_RESET[j];
         end
      end else begin
         state_ff <= state_in;
         if (csr_we && (csr_index == REG_POINT_COUNT)) begin
            cnt_ff <= csr_wdata[CNT_W-1:0];
         end
         for (int j = 0; j < MAX_POINTS; j++) begin
            if (csr_we && (csr_index == REG_NODE_BASE + IDX_W'(j))) begin
               node_ff[j] <= csr_wdata;
            end
         end
      end
      p_ff       <= p_in;
      n_ff       <= n_in;
      x_ff       <= x_in;
      np_ff      <= np_in;
      i_ff       <= i_in;
      k_ff       <= k_in;
      c_ff       <= c_in;
      w_ff       <= w_in;
      acc_ff     <= acc_in;
      sgn_ff     <= sgn_in;
      den_ff     <= den_in;
      den_neg_ff <= den_neg_in;
      num_ff     <= num_in;
      num_neg_ff <= num_neg_in;
      sum_ff     <= sum_in;
      sat_ff     <= sat_in;
      val_ff     <= val_in;
      slope_ff   <= slope_in;
      status_ff  <= status_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {slope_ff, val_ff};
   assign rsp_tuser  = status_ff;

endmodule

@@ sv/lbe_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbe_divider
// Restoring divider, one quotient bit per cycle, round half away, saturate.
// ----------------------------------------------------------------------------
module lbe_divider import lbe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  div_cmd_type       cmd,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [PROD_W-1:0] divisor,
   output div_res_type       res
);

   localparam logic [RES_W+1:0] POS_LIM = (RES_W+2)'((64'd1 << (RES_W - 1)) - 64'd1);
   localparam logic [RES_W+1:0] NEG_LIM = (RES_W+2)'(64'd1 << (RES_W - 1));
   localparam logic [RES_W-1:0] POS_SAT = RES_W'((64'd1 << (RES_W - 1)) - 64'd1);
   localparam logic [RES_W-1:0] NEG_SAT = RES_W'(64'd1 << (RES_W - 1));

   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [PROD_W-1:0]    den_ff, den_in;
   logic [PROD_W-1:0]    rem_ff, rem_in;
   logic [RES_W:0]       q_ff, q_in;
   logic                 ovf_ff, ovf_in;
   logic                 neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 fin_ff, fin_in;

   logic [PROD_W:0]  r2;
   logic [PROD_W:0]  r2_diff;
   logic             ge;
   logic             rnd;
   logic [RES_W+1:0] qr;
   logic             over;

   assign r2      = {rem_ff, dvd_ff[DIV_W-1]};
   assign ge      = r2 >= {1'b0, den_ff};
   assign r2_diff = r2 - {1'b0, den_ff};

   // final rounding from the last remainder
   assign rnd  = {rem_ff, 1'b0} >= {1'b0, den_ff};
   assign qr   = {1'b0, q_ff} + (RES_W+2)'(rnd);
   assign over = ovf_ff || (neg_ff ? (qr > NEG_LIM) : (qr > POS_LIM));

   assign res.done  = fin_ff;
   assign res.sat   = over;
   assign res.value = over ? (neg_ff ? NEG_SAT : POS_SAT)
                           : (neg_ff ? (RES_W'(0) - qr[RES_W-1:0]) : qr[RES_W-1:0]);

   always_comb begin
      dvd_in  = dvd_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      fin_in  = 1'b0;
      if (cmd.start) begin
         dvd_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         q_in    = '0;
         ovf_in  = 1'b0;
         neg_in  = cmd.neg;
         cnt_in  = DIV_CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         rem_in = ge ? r2_diff[PROD_W-1:0] : r2[PROD_W-1:0];
         q_in   = {q_ff[RES_W-1:0], ge};
         ovf_in = ovf_ff | q_ff[RES_W];
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
      neg_ff <= neg_in;
   end

endmodule

@@ sv/lbe_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbe_checker
// Port-level checks of the basis evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbe_checker import lbe_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]    rsp_tuser
);

   // stalled result beat holds
   `LBE_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // one request in flight: no new beat while a result waits
   `LBE_ASSERT(a_no_overlap, clock, reset, rsp_tvalid |-> !req_tready)

   // accepted request closes the input side in the following cycle
   `LBE_ASSERT(a_busy_after_accept, clock, reset, req_tvalid && req_tready |=> !req_tready)

   // error results carry zero data
   `LBE_ASSERT(a_err_zero, clock, reset, rsp_tvalid && (rsp_tuser == ST_ZERO_DEN || rsp_tuser == ST_BAD_INDEX) |-> rsp_tdata == '0)

endmodule

bind lagrange_basis_eval lbe_checker u_lbe_checker (.*);
